>>> design/rdq_pkg.sv
// Shared types and constants of the reversible deque.
package rdq_pkg;

   localparam int unsigned RDQ_DEPTH      = 1024;
   localparam int unsigned RDQ_DATA_WIDTH = 32;
   localparam int unsigned FUNC_W         = 3;
   localparam int unsigned VALUE_W        = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_REVERSE    = 3'd2,
      FUNC_POP_FRONT  = 3'd3,
      FUNC_POP_BACK   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_POPPED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

endpackage

>>> design/rdq_if.sv
// Request and response channel interfaces of the reversible deque.
interface rdq_req_if import rdq_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [VALUE_W-1:0] push_value;

   modport source (output valid, func, push_value, input ready);
   modport sink   (input valid, func, push_value, output ready);
endinterface

interface rdq_rsp_if import rdq_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic signed [VALUE_W-1:0] pop_value;

   modport source (output valid, status, pop_value, input ready);
   modport sink   (input valid, status, pop_value, output ready);
endinterface

>>> design/reversible_deque_core.sv
// Reversible deque top level: ring store, pointer logic and result pipeline.
//
// Usage: each request item carries func (push front, push back, reverse,
// pop front, pop back) and push_value. Every request gives exactly one
// response item with a status (done, popped, empty on pop, full on push)
// and pop_value, which is nonzero only for a successful pop.
// A request is taken at any clock edge where req valid and ready are high.
// The pointers, count and reversed flag update at that edge, and the ring
// store is written or read there, so the next request sees all effects.
// The response passes from acceptance through the registered store read
// and then the output register. Throughput is one item per cycle while
// the receiver takes responses, set by the single store port pair (one
// write and one read per cycle) and the registered pointer update.
// Reset clears the pointers, the count, the flag and both pipeline stages;
// req ready stays low while reset is high. The store itself is not cleared,
// since an entry is read only after it was written. When the receiver
// stalls, the output register and the read stage fill up, and req ready
// then drops until the response is taken.
module reversible_deque_core import rdq_pkg::*; #(
   parameter int unsigned DEPTH      = RDQ_DEPTH,
   parameter int unsigned DATA_WIDTH = RDQ_DATA_WIDTH
) (
   input logic        clock,
   input logic        reset,
   rdq_req_if.sink    req_ch,
   rdq_rsp_if.source  rsp_ch
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [IDX_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rev_ff, rev_in;

   logic                  s1_valid_ff, s1_valid_in;
   status_type            s1_status_ff, s1_status_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;

   logic                  req_fire, out_free, s1_move;
   logic                  wr_en, rd_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic                  is_push, is_pop, is_full, is_empty;
   logic [SUM_W-1:0]      push_sum, pop_sum;
   logic [IDX_W-1:0]      tail_wr_idx, tail_rd_idx, front_dec, front_inc;

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      return r[IDX_W-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign req_ch.ready = !reset && (!s1_valid_ff || out_free);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign is_push  = (req_ch.func == FUNC_PUSH_FRONT) || (req_ch.func == FUNC_PUSH_BACK);
   assign is_pop   = (req_ch.func == FUNC_POP_FRONT) || (req_ch.func == FUNC_POP_BACK);

   // Back slots: the one past the last entry for a push, the last entry for a pop.
   assign push_sum = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign pop_sum  = push_sum - SUM_W'(1);
   assign tail_wr_idx = ring_wrap(push_sum);
   assign tail_rd_idx = ring_wrap(pop_sum);
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);

   always_comb begin
      logic at_front;
      front_in     = front_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      s1_status_in = ST_DONE;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = tail_wr_idx;
      rd_addr      = tail_rd_idx;
      at_front     = 1'b0;
      case (req_ch.func)
         FUNC_REVERSE: begin
            rev_in = !rev_ff;
         end
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            // The reversed flag swaps which physical end is touched.
            at_front = (req_ch.func == FUNC_PUSH_FRONT) != rev_ff;
            if (is_full) begin
               s1_status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (at_front) begin
                  front_in = front_dec;
                  wr_addr  = front_dec;
               end
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            at_front = (req_ch.func == FUNC_POP_FRONT) != rev_ff;
            if (is_empty) begin
               s1_status_in = ST_EMPTY;
            end else begin
               s1_status_in = ST_POPPED;
               rd_en        = 1'b1;
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  rev_in = 1'b0;
               end
               if (at_front) begin
                  rd_addr  = front_ff;
                  front_in = front_inc;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && wr_en) begin
         mem[wr_addr] <= DATA_WIDTH'(req_ch.push_value);
      end
      if (req_fire && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            front_ff <= front_in;
            count_ff <= count_in;
            rev_ff   <= rev_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_status_ff <= s1_status_in;
      end
      if (s1_move) begin
         rsp_status_ff <= s1_status_ff;
         rsp_value_ff  <= (s1_status_ff == ST_POPPED) ?
                          VALUE_W'($signed(rd_data_ff)) : '0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.pop_value = rsp_value_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && is_empty) |=> (s1_status_ff == ST_EMPTY) && $stable(count_ff))
      else $error("pop on empty queue changed state or status");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_push && is_full) |=> $stable(count_ff) && $stable(front_ff))
      else $error("push on full queue changed state");

   a_last_pop_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && count_ff == CNT_W'(1)) |=> !rev_ff && count_ff == '0)
      else $error("reversed flag survived emptying pop");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready && s1_valid_ff) |-> !req_ch.ready)
      else $error("request taken with both stages blocked");

endmodule

>>> verif/reversible_deque_core_tb.sv
// Self-checking testbench for the reversible deque: directed and random traffic, scoreboard and predictor.
`timescale 1ns / 1ps

module reversible_deque_core_tb;
   import rdq_pkg::*;

   // Codes outside the defined operations; the block treats them as no-ops.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

   localparam int unsigned MISMATCH_SHOWN = 10;
   localparam int unsigned SETTLE_CYCLES  = 10;

   typedef struct {
      logic [FUNC_W-1:0]  op;
      logic [VALUE_W-1:0] value;
      bit                 drain_first;
   } deque_op_type;

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] value;
   } deque_result_type;

   logic clock;
   logic reset;

   rdq_req_if req_if ();
   rdq_rsp_if rsp_if ();

   reversible_deque_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   deque_op_type     op_queue[$];
   deque_result_type expected_results[$];

   // Predicted deque contents.
   logic [RDQ_DATA_WIDTH-1:0] ring_store [RDQ_DEPTH];
   int unsigned               head_slot;
   int unsigned               held_count;
   bit                        flipped;

   int unsigned planned_count;
   int unsigned total_items;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned mismatch_count;
   bit          send_calm;
   bit          take_calm;
   int unsigned send_gap;
   int unsigned take_stall;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic deque_result_type predict_deque(input logic [FUNC_W-1:0] op,
                                                      input logic [VALUE_W-1:0] value);
      deque_result_type res;
      int unsigned      slot;
      bit               phys_front;
      res.status = ST_DONE;
      res.value  = '0;
      case (op)
         FUNC_REVERSE: begin
            flipped = !flipped;
         end
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            phys_front = (op == FUNC_PUSH_FRONT) != flipped;
            if (held_count >= RDQ_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (phys_front) begin
                  head_slot = (head_slot + RDQ_DEPTH - 1) % RDQ_DEPTH;
                  slot = head_slot;
               end else begin
                  slot = (head_slot + held_count) % RDQ_DEPTH;
               end
               ring_store[slot] = value[RDQ_DATA_WIDTH-1:0];
               held_count++;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            phys_front = (op == FUNC_POP_FRONT) != flipped;
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_POPPED;
               if (phys_front) begin
                  slot = head_slot;
                  head_slot = (head_slot + 1) % RDQ_DEPTH;
               end else begin
                  slot = (head_slot + held_count - 1) % RDQ_DEPTH;
               end
               res.value = VALUE_W'(signed'(ring_store[slot]));
               held_count--;
               if (held_count == 0) flipped = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Mostly short gaps, a few long ones, and calm stretches with none at all.
   function automatic int unsigned idle_length(input bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] any_value();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic plan_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] value,
                          input bit drain_first = 1'b0);
      deque_op_type item;
      item.op = op;
      item.value = value;
      item.drain_first = drain_first;
      op_queue.insert(op_queue.size(), item);
      if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_BACK) begin
         if (planned_count < RDQ_DEPTH) planned_count++;
      end else if (op == FUNC_POP_FRONT || op == FUNC_POP_BACK) begin
         if (planned_count > 0) planned_count--;
      end
   endtask

   task automatic plan_random_op(input int unsigned push_weight);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         plan_op(FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), any_value());
      end else if (r < 3 + push_weight) begin
         plan_op($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, any_value(),
                 $urandom_range(0, 99) == 0);
      end else if (r < 13 + push_weight) begin
         plan_op(FUNC_REVERSE, any_value());
      end else begin
         plan_op($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT, any_value(),
                 $urandom_range(0, 99) == 0);
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN) $display("Mismatch: %s", msg);
   endtask

   // Request driver: holds an item until taken, then waits out a random gap.
   always @(posedge clock) begin : req_driver
      deque_op_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
         send_calm <= 1'b0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_if.valid && req_if.ready) items_sent++;
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (op_queue.size() != 0 &&
                      !(op_queue[0].drain_first && items_sent != results_seen)) begin
            item = op_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.func <= item.op;
            req_if.push_value <= item.value;
            if ($urandom_range(0, 49) == 0) send_calm <= !send_calm;
            send_gap <= idle_length(send_calm);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin : rsp_stall
      int unsigned g;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_stall <= 0;
         take_calm <= 1'b0;
      end else if (take_stall != 0) begin
         rsp_if.ready <= 1'b0;
         take_stall <= take_stall - 1;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if ($urandom_range(0, 49) == 0) take_calm <= !take_calm;
         g = idle_length(take_calm);
         rsp_if.ready <= (g == 0);
         take_stall <= (g == 0) ? 0 : g - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Scoreboard: predict on each accepted request, compare each accepted response.
   always @(posedge clock) begin : scoreboard
      deque_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            expected_results.insert(expected_results.size(),
                                    predict_deque(req_if.func, req_if.push_value));
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("unexpected response status %0d value %0h",
                                       rsp_if.status, rsp_if.pop_value));
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.status !== want.status || rsp_if.pop_value !== want.value)
                  note_mismatch($sformatf(
                     "response %0d: expected status %0d value %0h, got status %0d value %0h",
                     results_seen, want.status, want.value,
                     rsp_if.status, rsp_if.pop_value));
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      req_if.valid = 1'b0;
      req_if.func = FUNC_PUSH_FRONT;
      req_if.push_value = '0;
      rsp_if.ready = 1'b0;
      head_slot = 0;
      held_count = 0;
      flipped = 1'b0;
      planned_count = 0;
      total_items = 0;
      items_sent = 0;
      results_seen = 0;
      mismatch_count = 0;
      reset = 1'b1;

      // Directed: empty pops, reverse on empty, extremes, spare codes and the
      // flag clearing when a reversed deque runs dry.
      plan_op(FUNC_POP_FRONT, 32'h1234_5678);
      plan_op(FUNC_POP_BACK, 32'hFFFF_FFFF);
      plan_op(FUNC_REVERSE, 32'h0000_0000);
      plan_op(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
      plan_op(FUNC_PUSH_BACK, 32'h8000_0000);
      plan_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
      plan_op(FUNC_PUSH_BACK, 32'h0000_0000);
      plan_op(FUNC_SPARE_LO, 32'hDEAD_BEEF);
      plan_op(FUNC_SPARE_MID, 32'h0000_0001);
      plan_op(FUNC_SPARE_HI, 32'hFFFF_FFFF);
      plan_op(FUNC_POP_FRONT, 32'h0);
      plan_op(FUNC_POP_BACK, 32'h0);
      plan_op(FUNC_POP_FRONT, 32'h0);
      plan_op(FUNC_POP_BACK, 32'h0);
      plan_op(FUNC_PUSH_FRONT, 32'h5A5A_5A5A);
      plan_op(FUNC_PUSH_BACK, 32'hA5A5_A5A5);
      plan_op(FUNC_REVERSE, 32'h0);
      plan_op(FUNC_POP_FRONT, 32'h0);
      plan_op(FUNC_REVERSE, 32'h0);
      plan_op(FUNC_REVERSE, 32'h0);
      plan_op(FUNC_POP_BACK, 32'h0);
      plan_op(FUNC_POP_BACK, 32'h0);

      for (n = 0; n < 120; n++) plan_random_op(45);

      // Fill to capacity, with the sender first waiting for every response.
      plan_op(FUNC_REVERSE, any_value(), 1'b1);
      while (planned_count < RDQ_DEPTH) begin
         n = $urandom_range(0, 99);
         if (n < 4) plan_op(FUNC_REVERSE, any_value());
         else if (n < 6) plan_op($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT, 32'h0);
         else plan_op($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, any_value());
      end
      for (n = 0; n < 6; n++)
         plan_op($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, any_value());
      plan_op(FUNC_REVERSE, 32'h0);
      plan_op(FUNC_PUSH_FRONT, any_value());
      plan_op(FUNC_PUSH_BACK, any_value());
      for (n = 0; n < 60; n++) plan_random_op(30);
      total_items = op_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every planned item gives exactly one response.
      do @(posedge clock);
      while (results_seen < total_items);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
design/rdq_pkg.sv
design/rdq_if.sv
design/reversible_deque_core.sv
verif/reversible_deque_core_tb.sv
